[design/gtq_pkg.sv]
// ----------------------------------------------------------------------------
// gtq_pkg: shared definitions for the grouped team queue
// Status and command codes, field widths and the modulo-3 group fold.
// ----------------------------------------------------------------------------
package gtq_pkg;

    localparam int NUM_GROUPS = 3;
    localparam int VALUE_W    = 31;
    localparam int GROUP_W    = 2;

    typedef logic [GROUP_W-1:0] group_t;
    typedef logic [1:0]         status_t;

    // command codes
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result codes
    localparam status_t ST_DEQ_OK   = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_ENQ_OK   = 2'd2;
    localparam status_t ST_ENQ_FULL = 2'd3;

    // value modulo 3: every even power of two is 1 mod 3, so fold halves
    // together until a few bits remain, then one compare and subtract.
    function automatic group_t group_of(input logic [VALUE_W-1:0] v);
        logic [16:0] f16;
        logic [9:0]  f8;
        logic [6:0]  f4;
        logic [3:0]  f2;
        logic [2:0]  f1;
        f16 = 17'(v[15:0]) + 17'(v[30:16]);
        f8  = 10'(f16[7:0]) + 10'(f16[16:8]);
        f4  = 7'(f8[3:0]) + 7'(f8[9:4]);
        f2  = 4'(f4[1:0]) + 4'(f4[3:2]) + 4'(f4[5:4]) + 4'(f4[6]);
        f1  = 3'(f2[1:0]) + 3'(f2[3:2]);
        return (f1 >= 3'd3) ? GROUP_W'(f1 - 3'd3) : f1[GROUP_W-1:0];
    endfunction

endpackage

[design/grouped_team_queue.sv]
// ----------------------------------------------------------------------------
// grouped_team_queue: team queue with three groups
// One FIFO per group in a shared store, plus the order of present groups.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready, kind, value): kind 0 enqueues value,
//   kind 1 dequeues the front entry. The group of a value is value mod 3; a
//   value joins behind its group's last member, or at the back of the queue.
//   Output channel (out_valid/out_ready, status, out_value): exactly one
//   result transfer per input transfer, in order. out_value is the removed
//   value on a successful dequeue and 0 otherwise.
//   Order: the input register takes the item, then decision, state update
//   and store access load the result register that drives the output.
//   Throughput: one item per cycle while out_ready is high; every item
//   touches one group FIFO's head or tail and the three-entry group order,
//   with at most one store write or read (none for a full or empty reply).
//   Reset: all FIFOs empty, group order cleared; the store is not cleared.
//   Stall: while out_ready is low the result register holds, the input
//   register takes one more item, then in_ready drops.
// ----------------------------------------------------------------------------
module grouped_team_queue
    import gtq_pkg::*;
#(
    parameter int GROUP_DEPTH = 256
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output status_t            status,
    output logic [VALUE_W-1:0] out_value
);

    localparam int PTR_W     = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int CNT_W     = $clog2(GROUP_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_GROUPS * GROUP_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(GROUP_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(GROUP_DEPTH - 1);
    localparam logic [PTR_W-1:0]  PTR_ONE  = PTR_W'(1);
    localparam logic [ADDR_W-1:0] BASE_1   = ADDR_W'(GROUP_DEPTH);
    localparam logic [ADDR_W-1:0] BASE_2   = ADDR_W'(2 * GROUP_DEPTH);

    // input register
    logic               a_vld_reg;
    logic               a_kind_reg;
    logic [VALUE_W-1:0] a_value_reg;
    group_t             a_grp_reg;

    // queue state
    logic [PTR_W-1:0] rd_ptr_reg [NUM_GROUPS];
    logic [PTR_W-1:0] rd_ptr_next[NUM_GROUPS];
    logic [PTR_W-1:0] wr_ptr_reg [NUM_GROUPS];
    logic [PTR_W-1:0] wr_ptr_next[NUM_GROUPS];
    logic [CNT_W-1:0] cnt_reg    [NUM_GROUPS];
    logic [CNT_W-1:0] cnt_next   [NUM_GROUPS];
    group_t           order_reg  [NUM_GROUPS];
    group_t           order_next [NUM_GROUPS];
    logic [1:0]       present_reg;
    logic [1:0]       present_next;

    // group FIFO store
    logic [VALUE_W-1:0] store_mem [MEM_DEPTH];

    // result register
    logic               b_vld_reg;
    status_t            b_status_reg;
    logic [VALUE_W-1:0] b_data_reg;

    logic             b_load;
    logic             a_fire;
    logic             in_fire;
    group_t           enq_grp;
    group_t           deq_grp;
    logic             enq_full;
    logic             q_empty;
    logic             do_enq;
    logic             do_deq;
    status_t          res_status;
    logic [PTR_W-1:0] wr_ptr_cur;
    logic [PTR_W-1:0] rd_ptr_cur;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // handshake: the result register frees up when empty or taken
    assign b_load   = !b_vld_reg || out_ready;
    assign a_fire   = a_vld_reg && b_load;
    assign in_ready = !a_vld_reg || b_load;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire)
        begin
            a_kind_reg  <= kind;
            a_value_reg <= value;
            a_grp_reg   <= group_of(value);
        end
    end

    // decision for the item in the input register
    assign enq_grp  = a_grp_reg;
    assign deq_grp  = order_reg[0];
    assign enq_full = (cnt_reg[enq_grp] == CNT_FULL);
    assign q_empty  = (present_reg == 2'd0);
    assign do_enq   = a_fire && (a_kind_reg == KIND_ENQ) && !enq_full;
    assign do_deq   = a_fire && (a_kind_reg == KIND_DEQ) && !q_empty;

    always_comb begin
        priority if (a_kind_reg == KIND_DEQ)
        begin
            res_status = q_empty ? ST_EMPTY : ST_DEQ_OK;
        end
        else
        begin
            res_status = enq_full ? ST_ENQ_FULL : ST_ENQ_OK;
        end
    end

    // tail and head pointers with wrap at the group depth
    assign wr_ptr_cur = wr_ptr_reg[enq_grp];
    assign rd_ptr_cur = rd_ptr_reg[deq_grp];
    assign wr_ptr_inc = (wr_ptr_cur == PTR_LAST) ? '0 : wr_ptr_cur + PTR_ONE;
    assign rd_ptr_inc = (rd_ptr_cur == PTR_LAST) ? '0 : rd_ptr_cur + PTR_ONE;

    always_comb begin
        unique case (enq_grp)
            2'd1:    wr_addr = BASE_1 + ADDR_W'(wr_ptr_cur);
            2'd2:    wr_addr = BASE_2 + ADDR_W'(wr_ptr_cur);
            default: wr_addr = ADDR_W'(wr_ptr_cur);
        endcase
        unique case (deq_grp)
            2'd1:    rd_addr = BASE_1 + ADDR_W'(rd_ptr_cur);
            2'd2:    rd_addr = BASE_2 + ADDR_W'(rd_ptr_cur);
            default: rd_addr = ADDR_W'(rd_ptr_cur);
        endcase
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            rd_ptr_next[g] = rd_ptr_reg[g];
            wr_ptr_next[g] = wr_ptr_reg[g];
            cnt_next[g]    = cnt_reg[g];
            order_next[g]  = order_reg[g];
        end
        present_next = present_reg;
        if (do_enq)
        begin
            wr_ptr_next[enq_grp] = wr_ptr_inc;
            cnt_next[enq_grp]    = cnt_reg[enq_grp] + CNT_ONE;
            // first member of its group: group goes to the back
            if (cnt_reg[enq_grp] == '0 && present_reg != 2'd3)
            begin
                order_next[present_reg] = enq_grp;
                present_next            = present_reg + 2'd1;
            end
        end
        if (do_deq)
        begin
            rd_ptr_next[deq_grp] = rd_ptr_inc;
            cnt_next[deq_grp]    = cnt_reg[deq_grp] - CNT_ONE;
            // last member leaves: the remaining groups move up
            if (cnt_reg[deq_grp] == CNT_ONE)
            begin
                order_next[0] = order_reg[1];
                order_next[1] = order_reg[2];
                present_next  = present_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                rd_ptr_reg[g] <= '0;
                wr_ptr_reg[g] <= '0;
                cnt_reg[g]    <= '0;
                order_reg[g]  <= '0;
            end
            present_reg <= 2'd0;
        end
        else
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                rd_ptr_reg[g] <= rd_ptr_next[g];
                wr_ptr_reg[g] <= wr_ptr_next[g];
                cnt_reg[g]    <= cnt_next[g];
                order_reg[g]  <= order_next[g];
            end
            present_reg <= present_next;
        end
    end

    // store: tail write on enqueue, registered head read on dequeue
    always_ff @(posedge clk) begin
        if (do_enq)
        begin
            store_mem[wr_addr] <= a_value_reg;
        end
        if (do_deq)
        begin
            b_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            b_vld_reg    <= 1'b0;
            b_status_reg <= ST_EMPTY;
        end
        else if (b_load)
        begin
            b_vld_reg <= a_vld_reg;
            if (a_vld_reg)
            begin
                b_status_reg <= res_status;
            end
        end
    end

    assign out_valid = b_vld_reg;
    assign status    = b_status_reg;
    assign out_value = (b_status_reg == ST_DEQ_OK) ? b_data_reg : '0;

endmodule

[verif/tb_grouped_team_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grouped_team_queue: self-checking bench for the grouped team queue
// Drives enqueue and dequeue requests with random gaps and output stalls.
// A tracker keeps its own per-group lists and group order, predicts every
// reply, and compares each reply field by field in transfer order.
// ----------------------------------------------------------------------------

package gtq_tb_pkg;

    import gtq_pkg::*;

    // Own copy of the team queue: one list per group plus the order in
    // which the groups currently present stand in the line.
    class team_order_tracker;

        typedef struct packed {
            status_t            st;
            logic [VALUE_W-1:0] val;
        } reply_t;

        int unsigned        depth;
        logic [VALUE_W-1:0] members [NUM_GROUPS][$];
        group_t             group_line[$];
        reply_t             expected_replies[$];
        int unsigned        mismatches;
        int unsigned        replies_seen;
        int unsigned        deq_hits;
        int unsigned        empty_hits;
        int unsigned        full_hits;

        function new(int unsigned d);
            depth        = d;
            mismatches   = 0;
            replies_seen = 0;
            deq_hits     = 0;
            empty_hits   = 0;
            full_hits    = 0;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch @%0t: %s", $time, msg);
        endtask

        // Work out the reply to one accepted request and update the lists.
        function void note_request(logic k, logic [VALUE_W-1:0] v);
            reply_t r;
            group_t g;
            r.st  = ST_ENQ_OK;
            r.val = '0;
            if (k == KIND_ENQ)
            begin
                g = group_t'(v % 31'd3);
                if (members[g].size() >= depth)
                begin
                    r.st = ST_ENQ_FULL;
                    full_hits++;
                end
                else
                begin
                    // a group with nobody queued joins at the back of the line
                    if (members[g].size() == 0)
                        group_line.push_back(g);
                    members[g].push_back(v);
                end
            end
            else if (group_line.size() == 0)
            begin
                r.st = ST_EMPTY;
                empty_hits++;
            end
            else
            begin
                g     = group_line[0];
                r.st  = ST_DEQ_OK;
                r.val = members[g].pop_front();
                if (members[g].size() == 0)
                    void'(group_line.pop_front());
                deq_hits++;
            end
            expected_replies.push_back(r);
        endfunction

        task check_reply(status_t st, logic [VALUE_W-1:0] val);
            reply_t want;
            replies_seen++;
            if (expected_replies.size() == 0)
            begin
                report($sformatf("reply %0d arrived with nothing outstanding", replies_seen));
                return;
            end
            want = expected_replies.pop_front();
            if (st !== want.st)
                report($sformatf("reply %0d status %0d, wanted %0d",
                                 replies_seen, st, want.st));
            if (val !== want.val)
                report($sformatf("reply %0d out_value %0h, wanted %0h",
                                 replies_seen, val, want.val));
        endtask

    endclass

endpackage

module tb_grouped_team_queue;

    import gtq_pkg::*;
    import gtq_tb_pkg::*;

    localparam int GROUP_DEPTH  = 256;
    localparam int TARGET_ITEMS = 1600;
    // Longest stretch without any transfer in a correct run is a long
    // sender gap or output stall plus pipeline latency; allow plenty of
    // headroom on top.
    localparam int IDLE_LIMIT   = 2000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic               out_valid;
    logic               out_ready;
    status_t            status;
    logic [VALUE_W-1:0] out_value;

    team_order_tracker  tracker;
    bit                 calm;          // no gaps or stalls while set
    int unsigned        sent;
    int unsigned        idle_cycles;

    grouped_team_queue #(
        .GROUP_DEPTH (GROUP_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_value (out_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [VALUE_W-1:0] any_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 8)
            return VALUE_MAX;
        return VALUE_W'($urandom);
    endfunction

    // A random value whose group is g; 3*k+g stays within 31 bits.
    function automatic logic [VALUE_W-1:0] value_in_group(group_t g);
        int unsigned k;
        k = $urandom_range(0, 715827881);
        return VALUE_W'(3 * k + g);
    endfunction

    // One request transfer. The optional gap comes first, so the valid left
    // high by the previous transfer is either lowered or reused in the same
    // step, never both. Returns at the edge where the transfer happens.
    task automatic send(input logic k, input logic [VALUE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        tracker.note_request(k, v);
        sent++;
    endtask

    task automatic enq(input logic [VALUE_W-1:0] v);
        send(KIND_ENQ, v);
    endtask

    // value is don't-care on a dequeue, so it carries noise
    task automatic deq();
        send(KIND_DEQ, VALUE_W'($urandom));
    endtask

    // Hold the sender off until every outstanding reply has come back.
    task automatic drain_replies();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.expected_replies.size() != 0);
    endtask

    // Push one group past its depth so the last few enqueues are dropped.
    task automatic fill_group(input group_t g);
        repeat (GROUP_DEPTH + 6)
        begin
            enq(value_in_group(g));
        end
    endtask

    // One random phase: a mix biased towards enqueue or dequeue, or a
    // fill of one group followed by one and a half group depths of dequeues.
    task automatic run_phase();
        int     mode;
        int     len;
        int     enq_pct;
        group_t g;
        mode = $urandom_range(0, 6);
        calm = ($urandom_range(0, 3) == 0);
        len  = $urandom_range(30, 120);
        case (mode)
            0, 1: enq_pct = 50;
            2, 3: enq_pct = 75;
            4, 5: enq_pct = 25;
            default: enq_pct = -1;
        endcase
        if (enq_pct < 0)
        begin
            g = group_t'($urandom_range(0, NUM_GROUPS - 1));
            fill_group(g);
            repeat (3 * GROUP_DEPTH / 2) deq();
        end
        else
        begin
            repeat (len)
            begin
                if ($urandom_range(0, 99) < enq_pct)
                    enq(any_value());
                else
                    deq();
            end
        end
    endtask

    // Output side: random stalls, with calm stretches that never stall.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = pick_gap();
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Reply checker: every transfer on the output is matched in order.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            tracker.check_reply(status, out_value);
    end

    // Watchdog: too long without a transfer on either side ends the run.
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_ready === 1'b1) ||
            (out_valid === 1'b1 && out_ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        tracker     = new(GROUP_DEPTH);
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_ENQ;
        value       = '0;
        out_ready   = 1'b0;
        calm        = 1'b0;
        sent        = 0;
        idle_cycles = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty dequeue, extreme values, members joining
        // behind their own group, the front group emptying and leaving,
        // and a group coming back in at the back of the line.
        deq();                          // nothing queued yet
        enq('0);                        // group 0 opens the line
        enq(VALUE_MAX);                 // group 1
        enq(31'd2);                     // group 2
        enq(31'd3);                     // group 0, joins behind 0
        enq(VALUE_MAX - 31'd1);         // group 0 again
        enq(31'd4);                     // group 1, behind VALUE_MAX
        deq();
        deq();
        deq();                          // last of group 0 leaves the line
        enq(31'd6);                     // group 0 rejoins at the back
        deq();
        deq();
        deq();
        deq();                          // line now empty
        deq();                          // empty again
        enq(31'd1);
        send(KIND_DEQ, VALUE_MAX);      // payload ignored on dequeue
        deq();                          // empty once more

        // A full group early on, then wait for every reply before the
        // line is drained again (pointer wrap follows naturally).
        fill_group(group_t'($urandom_range(0, NUM_GROUPS - 1)));
        drain_replies();
        repeat (GROUP_DEPTH + 10) deq();

        // Random phases until enough requests have gone in.
        while (sent < TARGET_ITEMS)
            run_phase();

        // Wind down: all replies back, then an extra wait to catch
        // anything stray from the two-stage pipeline.
        calm = 1'b0;
        drain_replies();
        repeat (10) @(posedge clk);

        $display("Run: %0d requests in, %0d replies checked", sent, tracker.replies_seen);
        $display("Predicted %0d dequeues, %0d empty replies, %0d full-group drops",
                 tracker.deq_hits, tracker.empty_hits, tracker.full_hits);
        if (tracker.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
